@@ sv/zscore_standardizer_assert.svh @@
// ----------------------------------------------------------------------------
// zscore_standardizer assertion macros
// Shared assertion forms for the z-score standardizer.
// ----------------------------------------------------------------------------
`ifndef ZSCORE_STANDARDIZER_ASSERT_SVH
`define ZSCORE_STANDARDIZER_ASSERT_SVH

// same-cycle implication
`define ZS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ZS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/zs_pkg.sv @@
// ----------------------------------------------------------------------------
// zs_pkg
// Widths, codes and sequencer constants of the z-score standardizer.
// ----------------------------------------------------------------------------
`default_nettype none

package zs_pkg;
   localparam int PIXEL_W   = 16;
   localparam int ZSCORE_W  = 32;
   localparam int STATUS_W  = 3;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;
   localparam int SUM_W     = 40;
   localparam int SQ_W      = 55;
   localparam int CNT_W     = 25;
   localparam int INV_W     = 49;
   localparam int NUM_W     = 80;
   localparam int ALU_W     = 112;
   localparam int QW        = 64;
   localparam int STEP_W    = 7;
   localparam int MAX_PIXELS = 16777216;

   localparam logic [STEP_W-1:0] QW_STEPS   = STEP_W'(QW - 1);
   localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(ALU_W / 2 - 1);

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_ZSCORE    = 3'd0;
   localparam status_type ST_NODATA    = 3'd1;
   localparam status_type ST_READY     = 3'd2;
   localparam status_type ST_NO_VALID  = 3'd3;
   localparam status_type ST_NOT_READY = 3'd4;

   // register index taken from paddr bit 2
   localparam logic REG_NODATA_ENABLE = 1'b0;
   localparam logic REG_NODATA_VALUE  = 1'b1;
endpackage

`default_nettype wire

@@ sv/zscore_standardizer.sv @@
// ----------------------------------------------------------------------------
// zscore_standardizer
// Two-pass z-score standardizer over one shared 112-bit add/subtract unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: tdata = pixel, tuser = kind (0 statistics, 1 output),
//   tlast = last pixel of the statistics pass.
//   rsp_ channel: tdata = Q15.16 z-score, tuser = status.
//   A statistics pixel without tlast passes through S_ACC and gives no transaction.
//   The last statistics pixel runs the end-of-pass sequence on the shared
//   adder: 64 divide steps for the mean, 2 x 64 shift-add multiply steps,
//   56 square-root steps and 2 x 64 divide steps.
//   An output pixel with ready statistics that is not nodata runs one 64-step shift-add multiply.
//   req_tready is high only while the sequencer is idle.
//   The result sits in an output register; a new pixel is accepted while it
//   waits, and the next result waits in the sequencer until rsp_tready.
//   Reset clears statistics, the csr registers and the output valid flag.
//   csr_ port writes nodata_enable (0x0) and nodata_value (0x4).
// ----------------------------------------------------------------------------
`default_nettype none

module zscore_standardizer (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [zs_pkg::PIXEL_W-1:0]     req_tdata,   // [15:0] pixel
   input  wire                            req_tuser,   // [0] kind
   input  wire                            req_tlast,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [zs_pkg::ZSCORE_W-1:0]    rsp_tdata,   // [31:0] zscore
   output logic [zs_pkg::STATUS_W-1:0]    rsp_tuser,   // [2:0] status
   input  wire                            csr_psel,
   input  wire                            csr_penable,
   input  wire                            csr_pwrite,
   input  wire  [zs_pkg::ADDR_W-1:0]      csr_paddr,
   input  wire  [zs_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [zs_pkg::DATA_W-1:0]      csr_prdata,
   output logic                           csr_pready
);
   import zs_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ACC  = 4'd1;
   localparam logic [3:0] S_CHK  = 4'd2;
   localparam logic [3:0] S_DIVM = 4'd3;
   localparam logic [3:0] S_MUL1 = 4'd4;
   localparam logic [3:0] S_MUL2 = 4'd5;
   localparam logic [3:0] S_SUBN = 4'd6;
   localparam logic [3:0] S_SQRT = 4'd7;
   localparam logic [3:0] S_DIVS = 4'd8;
   localparam logic [3:0] S_DIVI = 4'd9;
   localparam logic [3:0] S_ZPRE = 4'd10;
   localparam logic [3:0] S_ZMUL = 4'd11;
   localparam logic [3:0] S_ZSAT = 4'd12;
   localparam logic [3:0] S_EMIT = 4'd13;

   logic [3:0]              state_ff, state_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   logic [ALU_W-1:0]        acc_ff, acc_in, opd_ff, opd_in;
   logic [QW-1:0]           mlt_ff, mlt_in;
   logic [NUM_W-1:0]        pa_ff, pa_in;
   logic [SUM_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic                    last_ff, last_in, nd_ff, nd_in;
   logic signed [PIXEL_W-1:0] px_ff, px_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic signed [ZSCORE_W-1:0] mean_ff, mean_in;
   logic [INV_W-1:0]        inv_ff, inv_in;
   logic                    sv_ff, sv_in;
   status_type              res_ff, res_in;
   logic [ZSCORE_W-1:0]     resz_ff, resz_in;
   logic                    nde_ff;
   logic [PIXEL_W-1:0]      ndv_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ZSCORE_W-1:0]     rsp_data_ff;
   status_type              rsp_user_ff;

   // shared adder
   logic [ALU_W-1:0] alu_a, alu_b;
   logic             alu_sub;
   logic [ALU_W:0]   alu_sum;
   logic             carry;
   logic [QW-1:0]    q_next;

   logic             req_fire, emit_go, csr_wr, is_nd;
   logic [SUM_W-1:0] sum_abs;
   logic [31:0]      sq_px;
   logic signed [33:0] diff;
   logic [63:0]      zq;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign is_nd      = nde_ff && (req_tdata == ndv_ff);
   assign emit_go    = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_NODATA_VALUE)
                     ? {{(DATA_W-PIXEL_W){1'b0}}, ndv_ff}
                     : {{(DATA_W-1){1'b0}}, nde_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : sum_ff;
   assign sq_px   = 32'($signed(px_ff) * $signed(px_ff));
   assign diff    = ($signed({{2{px_ff[PIXEL_W-1]}}, px_ff, 16'b0}))
                  - 34'(mean_ff);

   always_comb begin
      alu_a   = acc_ff;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         S_MUL1, S_MUL2, S_ZMUL: begin
            alu_b = mlt_ff[0] ? opd_ff : '0;
         end
         S_DIVM, S_DIVS, S_DIVI: begin
            alu_a   = {acc_ff[ALU_W-2:0], mlt_ff[QW-1]};
            alu_b   = opd_ff;
            alu_sub = 1'b1;
         end
         S_SQRT: begin
            alu_a   = {acc_ff[ALU_W-3:0], opd_ff[ALU_W-1:ALU_W-2]};
            alu_b   = {{(ALU_W-QW-2){1'b0}}, mlt_ff, 2'b01};
            alu_sub = 1'b1;
         end
         S_SUBN: begin
            alu_a   = {{(ALU_W-NUM_W){1'b0}}, pa_ff};
            alu_b   = acc_ff;
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = acc_ff;
         end
      endcase
      alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
              + {{ALU_W{1'b0}}, alu_sub};
      carry   = alu_sum[ALU_W];
      q_next  = {mlt_ff[QW-2:0], carry};
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff - 1'b1;
      acc_in   = acc_ff;
      opd_in   = opd_ff;
      mlt_in   = mlt_ff;
      pa_in    = pa_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      last_in  = last_ff;
      nd_in    = nd_ff;
      px_in    = px_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      n_in     = n_ff;
      mean_in  = mean_ff;
      inv_in   = inv_ff;
      sv_in    = sv_ff;
      res_in   = res_ff;
      resz_in  = resz_ff;
      zq       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               px_in   = req_tdata;
               nd_in   = is_nd;
               last_in = req_tlast;
               resz_in = '0;
               if (!req_tuser) begin
                  state_in = S_ACC;
               end else if (!sv_ff) begin
                  res_in   = ST_NOT_READY;
                  state_in = S_EMIT;
               end else if (is_nd) begin
                  res_in   = ST_NODATA;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_ZPRE;
               end
            end
         end
         S_ACC: begin
            if (!nd_ff && (32'(n_ff) < 32'(MAX_PIXELS))) begin
               sum_in = sum_ff + SUM_W'(px_ff);
               sq_in  = sq_ff + SQ_W'(sq_px);
               n_in   = n_ff + 1'b1;
            end
            state_in = last_ff ? S_CHK : S_IDLE;
         end
         S_CHK: begin
            if (n_ff == '0) begin
               sv_in    = 1'b0;
               res_in   = ST_NO_VALID;
               sum_in   = '0;
               sq_in    = '0;
               state_in = S_EMIT;
            end else begin
               mag_in   = sum_abs;
               neg_in   = sum_ff[SUM_W-1];
               mlt_in   = {{(QW-SUM_W-16){1'b0}}, sum_abs, 16'b0};
               opd_in   = ALU_W'(n_ff);
               acc_in   = '0;
               cnt_in   = QW_STEPS;
               state_in = S_DIVM;
            end
         end
         S_DIVM, S_DIVS, S_DIVI: begin
            acc_in = carry ? alu_sum[ALU_W-1:0] : alu_a;
            mlt_in = q_next;
            if (cnt_ff == '0) begin
               acc_in = '0;
               cnt_in = QW_STEPS;
               if (state_ff == S_DIVM) begin
                  mean_in  = neg_ff ? -$signed(q_next[ZSCORE_W-1:0])
                                    : $signed(q_next[ZSCORE_W-1:0]);
                  opd_in   = ALU_W'(sq_ff);
                  mlt_in   = QW'(n_ff);
                  state_in = S_MUL1;
               end else if (state_ff == S_DIVS) begin
                  // zero deviation becomes 1.0
                  opd_in   = (q_next == '0) ? ALU_W'(65536) : ALU_W'(q_next);
                  mlt_in   = QW'(1) << 48;
                  state_in = S_DIVI;
               end else begin
                  inv_in   = q_next[INV_W-1:0];
                  sv_in    = 1'b1;
                  res_in   = ST_READY;
                  sum_in   = '0;
                  sq_in    = '0;
                  n_in     = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_MUL1, S_MUL2, S_ZMUL: begin
            acc_in = alu_sum[ALU_W-1:0];
            opd_in = {opd_ff[ALU_W-2:0], 1'b0};
            mlt_in = {1'b0, mlt_ff[QW-1:1]};
            if (cnt_ff == '0) begin
               if (state_ff == S_MUL1) begin
                  pa_in    = alu_sum[NUM_W-1:0];
                  acc_in   = '0;
                  opd_in   = ALU_W'(mag_ff);
                  mlt_in   = QW'(mag_ff);
                  cnt_in   = QW_STEPS;
                  state_in = S_MUL2;
               end else if (state_ff == S_MUL2) begin
                  state_in = S_SUBN;
               end else begin
                  state_in = S_ZSAT;
               end
            end
         end
         S_SUBN: begin
            // variance numerator scaled by 2^32 for the root
            opd_in   = {alu_sum[NUM_W-1:0], 32'b0};
            acc_in   = '0;
            mlt_in   = '0;
            n_in     = n_ff;
            cnt_in   = SQRT_STEPS;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            acc_in = carry ? alu_sum[ALU_W-1:0] : alu_a;
            opd_in = {opd_ff[ALU_W-3:0], 2'b00};
            mlt_in = q_next;
            if (cnt_ff == '0) begin
               acc_in   = '0;
               opd_in   = ALU_W'(n_ff);
               cnt_in   = QW_STEPS;
               state_in = S_DIVS;
            end
         end
         S_ZPRE: begin
            neg_in   = diff[33];
            opd_in   = ALU_W'(diff[33] ? 34'(-diff) : 34'(diff));
            mlt_in   = QW'(inv_ff);
            acc_in   = '0;
            cnt_in   = QW_STEPS;
            state_in = S_ZMUL;
         end
         S_ZSAT: begin
            zq = (|acc_ff[ALU_W-1:96]) ? 64'h1_0000_0000 : acc_ff[95:32];
            if (neg_ff) begin
               resz_in = (zq > 64'h8000_0000) ? 32'h8000_0000 : 32'(-zq);
            end else begin
               resz_in = (zq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : zq[31:0];
            end
            res_in   = ST_ZSCORE;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         sq_ff        <= '0;
         n_ff         <= '0;
         mean_ff      <= '0;
         inv_ff       <= '0;
         sv_ff        <= 1'b0;
         nde_ff       <= 1'b0;
         ndv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         n_ff         <= n_in;
         mean_ff      <= mean_in;
         inv_ff       <= inv_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            if (csr_paddr[2] == REG_NODATA_VALUE) begin
               ndv_ff <= csr_pwdata[PIXEL_W-1:0];
            end else begin
               nde_ff <= csr_pwdata[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      opd_ff  <= opd_in;
      mlt_ff  <= mlt_in;
      pa_ff   <= pa_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      last_ff <= last_in;
      nd_ff   <= nd_in;
      px_ff   <= px_in;
      res_ff  <= res_in;
      resz_ff <= resz_in;
      if (emit_go) begin
         rsp_data_ff <= resz_ff;
         rsp_user_ff <= res_ff;
      end
   end

`include "zscore_standardizer_assert.svh"

   `ZS_ASSERT_NEXT(a_busy_after_output_pixel, clock, reset,
      req_fire && req_tuser && sv_ff && !is_nd, !req_tready,
      "output pixel did not start the multiply sequence")
   `ZS_ASSERT_NOW(a_inverse_set, clock, reset,
      sv_ff, inv_ff != '0,
      "statistics marked ready with a zero inverse deviation")
   `ZS_ASSERT_NOW(a_flag_zero_score, clock, reset,
      rsp_tvalid && (rsp_tuser != ST_ZSCORE), rsp_tdata == '0,
      "non-score status carries a nonzero value")

endmodule

`default_nettype wire

@@ test/tb_zscore_standardizer.sv @@
// ----------------------------------------------------------------------------
// tb_zscore_standardizer
// Self-checking bench for the two-pass z-score standardizer: statistics
// passes and output passes with random content and nodata settings, random
// idling on both stream sides and a long receiver hold-off; every result
// transaction is compared with a bit-exact prediction kept in a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
   logic [zs_pkg::ZSCORE_W-1:0] zscore;
   zs_pkg::status_type          status;
} zs_result_type;

class zscore_scoreboard;
   bit                   nd_enable;
   logic signed [15:0]   nd_value;
   longint               acc_sum;
   longint unsigned      acc_sq;
   longint unsigned      pix_count;
   longint               mean_q16;
   longint unsigned      inv_sd;
   bit                   stats_valid;
   zs_result_type        expect_q[$];
   int                   fail_count;

   function void clear_all();
      nd_enable = 0;
      nd_value = '0;
      acc_sum = 0;
      acc_sq = 0;
      pix_count = 0;
      mean_q16 = 0;
      inv_sd = 0;
      stats_valid = 0;
      expect_q.delete();
      fail_count = 0;
   endfunction

   function void set_reg(bit idx, logic [31:0] value);
      if (idx == zs_pkg::REG_NODATA_ENABLE) nd_enable = value[0];
      else nd_value = value[15:0];
   endfunction

   function void push_result(logic [31:0] z, zs_pkg::status_type st);
      zs_result_type r;
      r.zscore = z;
      r.status = st;
      expect_q.push_back(r);
   endfunction

   // end of statistics pass: exact integer variance, root and reciprocal
   function void close_stats();
      longint unsigned mag;
      logic [127:0]    num;
      logic [63:0]     root;
      logic [63:0]     cand;
      logic [63:0]     sd;
      if (pix_count == 0) begin
         stats_valid = 0;
         return;
      end
      mag = acc_sum < 0 ? longint'(-acc_sum) : longint'(acc_sum);
      mean_q16 = longint'((mag << 16) / pix_count);
      if (acc_sum < 0) mean_q16 = -mean_q16;
      num = 128'(pix_count) * 128'(acc_sq) - 128'(mag) * 128'(mag);
      num = num << 32;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (128'(cand) * 128'(cand) <= num) root = cand;
      end
      sd = root / pix_count;
      if (sd == 0) sd = 64'd65536;
      inv_sd = (64'd1 << 48) / sd;
      stats_valid = 1;
   endfunction

   function void note_input(bit kind, logic signed [15:0] px, bit last);
      bit              is_nd;
      longint          diff;
      longint unsigned dmag;
      logic [127:0]    prod;
      logic [63:0]     q;
      logic [31:0]     z;
      is_nd = nd_enable && (px == nd_value);
      if (kind == 1'b0) begin
         if (!is_nd && pix_count < zs_pkg::MAX_PIXELS) begin
            acc_sum += longint'(px);
            acc_sq += longint'(px) * longint'(px);
            pix_count++;
         end
         if (!last) return;
         close_stats();
         push_result('0, stats_valid ? zs_pkg::ST_READY : zs_pkg::ST_NO_VALID);
         acc_sum = 0;
         acc_sq = 0;
         pix_count = 0;
         return;
      end
      if (!stats_valid) begin
         push_result('0, zs_pkg::ST_NOT_READY);
         return;
      end
      if (is_nd) begin
         push_result('0, zs_pkg::ST_NODATA);
         return;
      end
      diff = longint'(px) * 65536 - mean_q16;
      dmag = diff < 0 ? longint'(-diff) : longint'(diff);
      prod = 128'(dmag) * 128'(inv_sd);
      q = (prod[127:96] != 0) ? 64'h1_0000_0000 : prod[95:32];
      if (diff < 0) z = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(q));
      else z = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      push_result(z, zs_pkg::ST_ZSCORE);
   endfunction

   function void check_result(logic [31:0] z, logic [2:0] st);
      zs_result_type e;
      if (expect_q.size() == 0) begin
         $error("unexpected result transaction: zscore %h status %0d", z, st);
         fail_count++;
         return;
      end
      e = expect_q.pop_front();
      if (st !== e.status) begin
         $error("status mismatch: expected %0d actual %0d", e.status, st);
         fail_count++;
      end
      if (z !== e.zscore) begin
         $error("zscore mismatch: expected %h actual %h", e.zscore, z);
         fail_count++;
      end
   endfunction
endclass

module tb_zscore_standardizer;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] pixel
   logic        req_tuser;    // [0] kind
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] zscore
   logic [2:0]  rsp_tuser;    // [2:0] status
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   zscore_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int sent;

   zscore_standardizer i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("zscore_standardizer regression: fail");
      $finish;
   end

   // receiver side: random stalls, or a counted hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_input(req_tuser, req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   task automatic csr_write(bit idx, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = idx ? 3'd4 : 3'd0;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic send(bit kind, logic [15:0] px, bit last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = px;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.expect_q.size() != 0) @(posedge clock);
      // a statistics pixel without last may still be in flight
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_pixel(logic [15:0] base);
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return sb.nd_value;
         3: return base + 16'($urandom_range(7)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_traffic(int n_items);
      logic [15:0] base;
      int          len;
      while (sent < n_items) begin
         if ($urandom_range(9) < 8) begin
            base = 16'($urandom);
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
               send(1'b0, pick_pixel(base), i == len - 1);
            len = $urandom_range(5, 25);
            for (int i = 0; i < len; i++)
               send(1'b1, pick_pixel(base), 1'($urandom));
         end else begin
            send(1'($urandom), 16'($urandom), $urandom_range(3) == 0);
         end
      end
   endtask

   initial begin
      sb = new();
      sb.clear_all();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 0;
      sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: output before statistics, tlast ignored in output pass
      send(1'b1, 16'h1234, 1'b1);
      send(1'b1, 16'h8000, 1'b0);
      drain();
      // statistics pass where every pixel is nodata
      csr_write(zs_pkg::REG_NODATA_ENABLE, 32'd1);
      csr_write(zs_pkg::REG_NODATA_VALUE, 32'hFFFF_8000);
      send(1'b0, 16'h8000, 1'b0);
      send(1'b0, 16'h8000, 1'b1);
      send(1'b1, 16'h0000, 1'b0);
      // single pixel: zero deviation replaced by 1.0, largest pixel, nodata and small scores of both signs
      send(1'b0, 16'h0000, 1'b1);
      send(1'b1, 16'h7FFF, 1'b0);
      send(1'b1, 16'h8000, 1'b0);
      send(1'b1, 16'h0001, 1'b0);
      send(1'b1, 16'hFFFF, 1'b0);
      // extremes mixed with nodata, nodata flagged in output pass
      send(1'b0, 16'h7FFF, 1'b0);
      send(1'b0, 16'h8000, 1'b0);
      send(1'b0, 16'h8001, 1'b0);
      send(1'b0, 16'h0000, 1'b1);
      send(1'b1, 16'h8000, 1'b0);
      send(1'b1, 16'h7FFF, 1'b0);
      send(1'b1, 16'h0000, 1'b1);
      drain();
      csr_write(zs_pkg::REG_NODATA_VALUE, 32'h0000_7FFF);
      send(1'b0, 16'h7FFF, 1'b0);
      send(1'b0, 16'h7FFF, 1'b1);
      send(1'b1, 16'h7FFF, 1'b0);
      drain();

      send_idle_pct = 32;
      recv_idle_pct = 55;
      csr_write(zs_pkg::REG_NODATA_ENABLE, 32'd0);
      csr_write(zs_pkg::REG_NODATA_VALUE, 32'd0);
      run_traffic(330);
      drain();

      send_idle_pct = 55;
      recv_idle_pct = 32;
      csr_write(zs_pkg::REG_NODATA_ENABLE, 32'd1);
      csr_write(zs_pkg::REG_NODATA_VALUE, $urandom);
      run_traffic(640);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(zs_pkg::REG_NODATA_VALUE, 32'h0000_8000);
      hold_cycles = 600;
      run_traffic(970);
      drain();
      repeat (500) @(posedge clock);

      if (sb.expect_q.size() != 0) begin
         $error("%0d expected results never arrived", sb.expect_q.size());
         sb.fail_count++;
      end
      if (sb.fail_count == 0) begin
         $display("zscore_standardizer regression: pass");
      end else begin
         $display("zscore_standardizer regression: fail");
      end
      $finish;
   end
endmodule

`default_nettype wire

@@ zscore_standardizer.f @@
+incdir+sv
sv/zs_pkg.sv
sv/zscore_standardizer.sv
test/tb_zscore_standardizer.sv
